// ===== rtl/dpt_pkg.sv =====
// shared constants and types for the djb2 presence table
package dpt_pkg;

   localparam int unsigned HASH_W       = 32;
   localparam int unsigned CFG_W        = 17;
   localparam int unsigned SLOT_FIELD_W = 16;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned STEP_W       = 5;
   localparam int unsigned HASH_SHIFT   = 5;
   localparam int unsigned SLOTS_DEF    = 65536;

   localparam logic [HASH_W-1:0] HASH_SEED  = 32'd5381;
   localparam logic [HASH_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
   localparam logic [CFG_W-1:0]  SIZE_RESET = 17'h1_0000;
   localparam logic [STEP_W-1:0] STEP_LAST  = 5'd31;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_CHECK  = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_LOOK  = 5'b10000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ===== rtl/dpt_ifs.sv =====
// request and response channel interfaces

interface dpt_req_if import dpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [BYTE_W-1:0] byte_value;
   logic              last_byte;

   modport source (output valid, mode, byte_value, last_byte, input ready);
   modport sink (input valid, mode, byte_value, last_byte, output ready);
endinterface

interface dpt_rsp_if import dpt_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [SLOT_FIELD_W-1:0] slot_index;
   logic [HASH_W-1:0]       insert_count;

   modport source (output valid, found, slot_index, insert_count, input ready);
   modport sink (input valid, found, slot_index, insert_count, output ready);
endinterface

// ===== rtl/djb2_presence_table.sv =====
// djb2 word hash into a one-bit presence table, insert and check
//
//   channel  dir  payload                              beat taken when
//   req      in   mode, byte_value, last_byte          valid && ready
//   rsp      out  found, slot_index, insert_count      valid && ready
//   csr      in   wr_data (table size)                 wr_en
//
// a byte that is not the last of its word is folded into the hash as it is taken
// the last byte runs through the accept that loads the modulo unit, 32 bit-serial
// modulo steps, the done strobe, a memory read and a lookup/update in ST_LOOK
// after reset a clearing sweep over every slot, then the step out of the
// clear state, runs before req.ready rises
// a waiting result holds only the lookup cycle; bytes of the next word flow
module djb2_presence_table import dpt_pkg::*; #(
   parameter int unsigned SLOTS = SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   dpt_req_if.sink          req,
   dpt_rsp_if.source        rsp,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int unsigned SLOT_W = $clog2(SLOTS);

   state_type               state_ff, state_in;
   logic [HASH_W-1:0]       hash_ff, hash_in;
   logic [HASH_W-1:0]       hash_next;
   logic                    mode_ff, mode_in;
   logic [CFG_W-1:0]        size_ff;
   logic [CFG_W-1:0]        eff_size;
   logic [HASH_W-1:0]       count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [SLOT_FIELD_W-1:0] slot_ff, slot_in;
   logic [HASH_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                    req_beat;
   logic                    div_start;
   logic [CFG_W-1:0]        remainder;
   logic [HASH_W-1:0]       rem_wide;
   div_stat_type            div_stat;
   mem_ctl_type             mem_ctl;
   logic                    mem_rd_data;
   logic                    mem_clearing;
   logic                    look_go;

   always_comb begin
      if (size_ff == '0) begin
         eff_size = CFG_W'(1);
      end else if (HASH_W'(size_ff) > HASH_W'(SLOTS)) begin
         eff_size = CFG_W'(SLOTS);
      end else begin
         eff_size = size_ff;
      end
   end

   assign req_beat  = req.valid && req.ready;
   assign hash_next = (hash_ff << HASH_SHIFT) + hash_ff + HASH_W'(req.byte_value);
   assign div_start = req_beat && req.last_byte;
   assign rem_wide  = HASH_W'(remainder);
   assign look_go   = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp.ready);

   dpt_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (hash_next),
      .divisor   (eff_size),
      .remainder (remainder),
      .stat      (div_stat)
   );

   always_comb begin
      mem_ctl.rd_en = (state_ff == ST_READ);
      mem_ctl.wr_en = look_go && (mode_ff == MODE_INSERT);
   end

   dpt_occ_mem #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .addr     (rem_wide[SLOT_W-1:0]),
      .rd_data  (mem_rd_data),
      .clearing (mem_clearing)
   );

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      found_in     = found_ff;
      slot_in      = slot_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (!mem_clearing) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               if (req.last_byte) begin
                  hash_in  = HASH_SEED;
                  mode_in  = req.mode;
                  state_in = ST_DIV;
               end else begin
                  hash_in = hash_next;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (look_go) begin
               if (mode_ff == MODE_INSERT && count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
               found_in     = mem_rd_data;
               slot_in      = rem_wide[SLOT_FIELD_W-1:0];
               rsp_count_in = count_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         hash_ff      <= HASH_SEED;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.found        = found_ff;
   assign rsp.slot_index   = slot_ff;
   assign rsp.insert_count = rsp_count_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_seed_reload: assert property (@(posedge clock) disable iff (reset)
      div_start |=> hash_ff == HASH_SEED)
      else $error("hash not reloaded after last byte");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_stat.busy)
      else $error("modulo unit busy while taking bytes");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("modulo result outside wait state");

endmodule

// ===== rtl/dpt_mod_unit.sv =====
// iterative restoring modulo unit, one dividend bit per cycle
module dpt_mod_unit import dpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] dividend,
   input  logic [CFG_W-1:0]  divisor,
   output logic [CFG_W-1:0]  remainder,
   output div_stat_type      stat
);

   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [CFG_W-1:0]  dsr_ff, dsr_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CFG_W:0]    trial;
   logic [CFG_W:0]    diff;

   always_comb begin
      trial = {rem_ff, dvd_ff[HASH_W-1]};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[CFG_W-1:0];
         end else begin
            rem_in = trial[CFG_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign remainder = rem_ff;
   assign stat      = '{busy: busy_ff, done: done_ff};

endmodule

// ===== rtl/dpt_occ_mem.sv =====
// one-bit occupancy memory with a clearing sweep after reset
module dpt_occ_mem import dpt_pkg::*; #(
   parameter int unsigned SLOTS  = SLOTS_DEF,
   parameter int unsigned SLOT_W = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  mem_ctl_type       ctl,
   input  logic [SLOT_W-1:0] addr,
   output logic              rd_data,
   output logic              clearing
);

   logic              occ_ff [SLOTS];
   logic              rd_data_ff;
   logic [SLOT_W-1:0] clr_addr_ff, clr_addr_in;
   logic              clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SLOT_W'(SLOTS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         occ_ff[clr_addr_ff] <= 1'b0;
      end else if (ctl.wr_en) begin
         occ_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= occ_ff[addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule
